/* rtl/bbq_pkg.sv */
// Shared types and constants for the beam billboard quad expander.
// Depends on nothing; every rtl module imports it.
package bbq_pkg;

	localparam int COORD_W   = 32;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int CROSS_W   = PROD_W + 1;
	localparam int MAG_W     = CROSS_W - 2;
	localparam int NORM_BITS = 30;
	localparam int SQ_W      = 2 * NORM_BITS;
	localparam int SUM_W     = SQ_W + 2;
	localparam int ROOT_W    = NORM_BITS + 1;
	localparam int HW_W      = 31;
	localparam int NUM_W     = NORM_BITS + HW_W;
	localparam int QUOT_W    = 32;
	localparam int LEN_W     = 7;
	localparam int UT_W      = 16;
	localparam int VT_W      = 15;
	localparam int TEX_W     = 16;
	localparam int IDX_W     = 3;
	localparam int DATA_W    = 32;

	typedef enum logic [IDX_W-1:0] {
		REG_HALF_WIDTH = 3'd0,
		REG_U_TILE     = 3'd1,
		REG_V_TILE     = 3'd2,
		REG_V_OFFSET   = 3'd3,
		REG_BEAM_COLOR = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		CORNER_START_LEFT  = 2'd0,
		CORNER_START_RIGHT = 2'd1,
		CORNER_END_LEFT    = 2'd2,
		CORNER_END_RIGHT   = 2'd3
	} corner_t;

	typedef struct packed {
		logic [2:0][COORD_W-1:0] st;
		logic [2:0][COORD_W-1:0] en;
		logic [2:0]              neg;
		logic                    deg;
	} bbq_pts_t;

endpackage

/* rtl/beam_billboard_quad_expand.sv */
// Beam billboard quad expander: one beam in, four vertex beats out.
// The datapath takes new beams while earlier ones are still in flight, but busy rises
// after each accepted beam to space them for the single vertex output.
// The 73-stage datapath never stalls.
// Reset clears the pipeline valid bits and sets the registers to their defaults.
module beam_billboard_quad_expand import bbq_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [COORD_W-1:0] camera_x,
	input  logic signed [COORD_W-1:0] camera_y,
	input  logic signed [COORD_W-1:0] camera_z,
	input  logic signed [COORD_W-1:0] start_x,
	input  logic signed [COORD_W-1:0] start_y,
	input  logic signed [COORD_W-1:0] start_z,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	input  logic signed [COORD_W-1:0] end_z,
	input  logic                      wr_en,
	input  logic [IDX_W-1:0]          wr_index,
	input  logic [DATA_W-1:0]         wr_data,
	output logic                      vertex_valid,
	output logic signed [COORD_W-1:0] vertex_x,
	output logic signed [COORD_W-1:0] vertex_y,
	output logic signed [COORD_W-1:0] vertex_z,
	output logic [TEX_W-1:0]          tex_u,
	output logic [TEX_W-1:0]          tex_v,
	output logic [1:0]                corner,
	output logic                      degenerate,
	output logic                      last
);

	logic [1:0] gap_q;
	logic accept;
	logic [HW_W-1:0] half_width_q;
	logic [UT_W-1:0] u_tile_q;
	logic [VT_W-1:0] v_tile_q;
	logic [VT_W-1:0] v_offset_q;
	logic [2:0][COORD_W-1:0] cam, st, en;

	logic fr_valid;
	logic [2:0][NORM_BITS-1:0] fr_m;
	bbq_pts_t fr_pts;
	logic sq_valid;
	logic [ROOT_W-1:0] sq_root;
	logic [2:0][NORM_BITS-1:0] sq_m;
	bbq_pts_t sq_pts;
	logic dv_valid;
	logic [2:0][QUOT_W-1:0] dv_quot;
	bbq_pts_t dv_pts;
	logic [COORD_W-1:0] vx, vy, vz;

	assign busy = (gap_q != 2'd0);
	assign accept = start && !busy;
	assign cam = {camera_z, camera_y, camera_x};
	assign st = {start_z, start_y, start_x};
	assign en = {end_z, end_y, end_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= 2'd0;
		end else if (accept) begin
			gap_q <= 2'd3;
		end else if (busy) begin
			gap_q <= gap_q - 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= HW_W'(65536);
			u_tile_q <= UT_W'(256);
			v_tile_q <= VT_W'(256);
			v_offset_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_HALF_WIDTH: half_width_q <= wr_data[HW_W-1:0];
				REG_U_TILE:     u_tile_q <= wr_data[UT_W-1:0];
				REG_V_TILE:     v_tile_q <= wr_data[VT_W-1:0];
				REG_V_OFFSET:   v_offset_q <= wr_data[VT_W-1:0];
				default: ;
			endcase
		end
	end

	bbq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.cam       (cam),
		.st        (st),
		.en        (en),
		.out_valid (fr_valid),
		.m         (fr_m),
		.pts       (fr_pts)
	);

	bbq_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.m_in      (fr_m),
		.pts_in    (fr_pts),
		.out_valid (sq_valid),
		.root      (sq_root),
		.m_out     (sq_m),
		.pts_out   (sq_pts)
	);

	bbq_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (sq_valid),
		.den_in     (sq_root),
		.m_in       (sq_m),
		.half_width (half_width_q),
		.pts_in     (sq_pts),
		.out_valid  (dv_valid),
		.quot       (dv_quot),
		.pts_out    (dv_pts)
	);

	bbq_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (dv_valid),
		.quot         (dv_quot),
		.pts_in       (dv_pts),
		.u_tile       (u_tile_q),
		.v_tile       (v_tile_q),
		.v_offset     (v_offset_q),
		.vertex_valid (vertex_valid),
		.vertex_x     (vx),
		.vertex_y     (vy),
		.vertex_z     (vz),
		.tex_u        (tex_u),
		.tex_v        (tex_v),
		.corner       (corner),
		.degenerate   (degenerate),
		.last         (last)
	);

	assign vertex_x = vx;
	assign vertex_y = vy;
	assign vertex_z = vz;

	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy ##1 busy ##1 busy)
		else $error("beam accepted inside the four cycle spacing");

	a_quad_runs: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && !last |=> vertex_valid)
		else $error("quad beats interrupted");

	a_corner_step: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && !last |=> corner == $past(corner) + 2'd1)
		else $error("corner sequence out of order");

	a_deg_stable: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && !last |=> $stable(degenerate))
		else $error("degenerate flag changed inside a quad");

endmodule

/* rtl/bbq_front.sv */
// Front end: differences, cross product, magnitude and normalization to NORM_BITS.
// Seven register stages. Depends on bbq_pkg.
module bbq_front import bbq_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [2:0][COORD_W-1:0]       cam,
	input  logic [2:0][COORD_W-1:0]       st,
	input  logic [2:0][COORD_W-1:0]       en,
	output logic                          out_valid,
	output logic [2:0][NORM_BITS-1:0]     m,
	output bbq_pts_t                      pts
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	bbq_pts_t pts_s1, pts_s2, pts_s3, pts_s4, pts_s5, pts_s6, pts_s7;
	logic signed [DIFF_W-1:0] a_s1 [3];
	logic signed [DIFF_W-1:0] b_s1 [3];
	logic signed [PROD_W-1:0] p_s2 [3];
	logic signed [PROD_W-1:0] q_s2 [3];
	logic [CROSS_W-1:0] c_s3 [3];
	logic [CROSS_W-1:0] cabs [3];
	logic [2:0][MAG_W-1:0] mag_s4, mag_s5, mag_s6;
	logic [MAG_W-1:0] mag_or;
	logic [71:0] mag_pad;
	logic [3:0] idx_c, idx_s5;
	logic [7:0] byte_c, byte_s5;
	logic [LEN_W-1:0] len_s6;
	logic [MAG_W+NORM_BITS-1:0] wide [3];
	logic [2:0][NORM_BITS-1:0] m_s7;

	function automatic logic [3:0] bitlen8(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd0;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) begin
				n = 4'(k + 1);
			end
		end
		return n;
	endfunction

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cabs[i] = c_s3[i][CROSS_W-1] ? (~c_s3[i] + CROSS_W'(1)) : c_s3[i];
		end
	end

	always_comb begin
		mag_or = mag_s4[0] | mag_s4[1] | mag_s4[2];
		mag_pad = {(72 - MAG_W)'(0), mag_or};
		idx_c = 4'd0;
		byte_c = 8'd0;
		for (int b = 0; b < 9; b++) begin
			if (mag_pad[8*b +: 8] != 8'd0) begin
				idx_c = 4'(b);
				byte_c = mag_pad[8*b +: 8];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wide[i] = {mag_s6[i], NORM_BITS'(0)} >> len_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			a_s1[i] <= {cam[i][COORD_W-1], cam[i]} - {st[i][COORD_W-1], st[i]};
			b_s1[i] <= {en[i][COORD_W-1], en[i]} - {st[i][COORD_W-1], st[i]};
		end
		pts_s1.st  <= st;
		pts_s1.en  <= en;
		pts_s1.neg <= 3'b000;
		pts_s1.deg <= 1'b0;

		p_s2[0] <= a_s1[1] * b_s1[2];
		q_s2[0] <= a_s1[2] * b_s1[1];
		p_s2[1] <= a_s1[2] * b_s1[0];
		q_s2[1] <= a_s1[0] * b_s1[2];
		p_s2[2] <= a_s1[0] * b_s1[1];
		q_s2[2] <= a_s1[1] * b_s1[0];
		pts_s2 <= pts_s1;

		for (int i = 0; i < 3; i++) begin
			c_s3[i] <= {p_s2[i][PROD_W-1], p_s2[i]} - {q_s2[i][PROD_W-1], q_s2[i]};
		end
		pts_s3 <= pts_s2;

		pts_s4.st  <= pts_s3.st;
		pts_s4.en  <= pts_s3.en;
		pts_s4.deg <= pts_s3.deg;
		for (int i = 0; i < 3; i++) begin
			mag_s4[i] <= cabs[i][MAG_W-1:0];
			pts_s4.neg[i] <= c_s3[i][CROSS_W-1];
		end

		mag_s5 <= mag_s4;
		idx_s5 <= idx_c;
		byte_s5 <= byte_c;
		pts_s5 <= pts_s4;

		mag_s6 <= mag_s5;
		len_s6 <= LEN_W'({idx_s5, 3'b000}) + LEN_W'(bitlen8(byte_s5));
		pts_s6.st  <= pts_s5.st;
		pts_s6.en  <= pts_s5.en;
		pts_s6.neg <= pts_s5.neg;
		pts_s6.deg <= (byte_s5 == 8'd0);

		for (int i = 0; i < 3; i++) begin
			m_s7[i] <= wide[i][NORM_BITS-1:0];
		end
		pts_s7 <= pts_s6;
	end

	assign out_valid = v_s7;
	assign m = m_s7;
	assign pts = pts_s7;

endmodule

/* rtl/bbq_sqrt.sv */
// Length of the normalized side vector: squares, sum and a pipelined
// integer square root, one result bit per stage. Depends on bbq_pkg.
module bbq_sqrt import bbq_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [2:0][NORM_BITS-1:0] m_in,
	input  bbq_pts_t                  pts_in,
	output logic                      out_valid,
	output logic [ROOT_W-1:0]         root,
	output logic [2:0][NORM_BITS-1:0] m_out,
	output bbq_pts_t                  pts_out
);

	logic v_s1;
	logic [2:0][SQ_W-1:0] sq_s1;
	logic [2:0][NORM_BITS-1:0] m_s1;
	bbq_pts_t pts_s1;

	logic v_sn [0:ROOT_W];
	logic [SUM_W-1:0] rem_sn [0:ROOT_W];
	logic [ROOT_W-1:0] root_sn [0:ROOT_W];
	logic [2:0][NORM_BITS-1:0] m_sn [0:ROOT_W];
	bbq_pts_t pts_sn [0:ROOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_sn[0] <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_sn[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s1[i] <= SQ_W'(m_in[i]) * SQ_W'(m_in[i]);
		end
		m_s1 <= m_in;
		pts_s1 <= pts_in;
		rem_sn[0] <= SUM_W'(sq_s1[0]) + SUM_W'(sq_s1[1]) + SUM_W'(sq_s1[2]);
		root_sn[0] <= '0;
		m_sn[0] <= m_s1;
		pts_sn[0] <= pts_s1;
	end

	for (genvar j = 0; j < ROOT_W; j++) begin : g_step
		localparam int B = ROOT_W - 1 - j;
		logic [SUM_W:0] trial;
		logic take;

		always_comb begin
			trial = ({(SUM_W + 1 - ROOT_W)'(0), root_sn[j]} << (B + 1))
				+ ((SUM_W + 1)'(1) << (2 * B));
			take = {1'b0, rem_sn[j]} >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[j+1] <= 1'b0;
			end else begin
				v_sn[j+1] <= v_sn[j];
			end
		end

		always_ff @(posedge clk) begin
			rem_sn[j+1] <= take ? SUM_W'({1'b0, rem_sn[j]} - trial) : rem_sn[j];
			root_sn[j+1] <= take ? (root_sn[j] | (ROOT_W'(1) << B)) : root_sn[j];
			m_sn[j+1] <= m_sn[j];
			pts_sn[j+1] <= pts_sn[j];
		end
	end

	assign out_valid = v_sn[ROOT_W];
	assign root = root_sn[ROOT_W];
	assign m_out = m_sn[ROOT_W];
	assign pts_out = pts_sn[ROOT_W];

endmodule

/* rtl/bbq_div.sv */
// Scaling of the side vector: product with the half width and three
// restoring dividers by the length, one quotient bit per stage. Depends on bbq_pkg.
module bbq_div import bbq_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [ROOT_W-1:0]         den_in,
	input  logic [2:0][NORM_BITS-1:0] m_in,
	input  logic [HW_W-1:0]           half_width,
	input  bbq_pts_t                  pts_in,
	output logic                      out_valid,
	output logic [2:0][QUOT_W-1:0]    quot,
	output bbq_pts_t                  pts_out
);

	logic [NUM_W-1:0] num [3];
	logic v_sn [0:QUOT_W];
	logic [2:0][ROOT_W-1:0] rem_sn [0:QUOT_W];
	logic [2:0][QUOT_W-1:0] nq_sn [0:QUOT_W];
	logic [ROOT_W-1:0] den_sn [0:QUOT_W];
	bbq_pts_t pts_sn [0:QUOT_W];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num[i] = NUM_W'(m_in[i]) * NUM_W'(half_width);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn[0] <= 1'b0;
		end else begin
			v_sn[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			rem_sn[0][i] <= ROOT_W'(num[i][NUM_W-1:QUOT_W]);
			nq_sn[0][i] <= num[i][QUOT_W-1:0];
		end
		den_sn[0] <= den_in;
		pts_sn[0] <= pts_in;
	end

	for (genvar j = 0; j < QUOT_W; j++) begin : g_step
		logic [ROOT_W:0] sh [3];
		logic [2:0] ge;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				sh[i] = {rem_sn[j][i], nq_sn[j][i][QUOT_W-1]};
				ge[i] = sh[i] >= {1'b0, den_sn[j]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[j+1] <= 1'b0;
			end else begin
				v_sn[j+1] <= v_sn[j];
			end
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				rem_sn[j+1][i] <= ge[i] ? ROOT_W'(sh[i] - {1'b0, den_sn[j]})
					: sh[i][ROOT_W-1:0];
				nq_sn[j+1][i] <= {nq_sn[j][i][QUOT_W-2:0], ge[i]};
			end
			den_sn[j+1] <= den_sn[j];
			pts_sn[j+1] <= pts_sn[j];
		end
	end

	assign out_valid = v_sn[QUOT_W];
	assign quot = nq_sn[QUOT_W];
	assign pts_out = pts_sn[QUOT_W];

endmodule

/* rtl/bbq_emit.sv */
// Vertex sequencer: holds one finished beam and sends its four corners,
// one beat per cycle, with saturated positions. Depends on bbq_pkg.
module bbq_emit import bbq_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [2:0][QUOT_W-1:0] quot,
	input  bbq_pts_t               pts_in,
	input  logic [UT_W-1:0]        u_tile,
	input  logic [VT_W-1:0]        v_tile,
	input  logic [VT_W-1:0]        v_offset,
	output logic                   vertex_valid,
	output logic [COORD_W-1:0]     vertex_x,
	output logic [COORD_W-1:0]     vertex_y,
	output logic [COORD_W-1:0]     vertex_z,
	output logic [TEX_W-1:0]       tex_u,
	output logic [TEX_W-1:0]       tex_v,
	output logic [1:0]             corner,
	output logic                   degenerate,
	output logic                   last
);

	localparam logic [COORD_W+1:0] POS_MAX = (COORD_W+2)'(32'h7FFF_FFFF);
	localparam logic [COORD_W+1:0] POS_MIN = {2'b11, 32'h8000_0000};

	logic active_q;
	corner_t corner_q;
	logic [2:0][QUOT_W-1:0] quot_q;
	bbq_pts_t pts_q;
	logic [2:0][COORD_W-1:0] base;
	logic [COORD_W+1:0] sum [3];
	logic [2:0][COORD_W-1:0] pos;

	logic valid_q, deg_q, last_q;
	logic [2:0][COORD_W-1:0] pos_q;
	logic [TEX_W-1:0] tu_q, tv_q;
	corner_t corner_out_q;

	always_comb begin
		base = corner_q[1] ? pts_q.en : pts_q.st;
		for (int i = 0; i < 3; i++) begin
			if (corner_q[0] ^ pts_q.neg[i]) begin
				sum[i] = {{2{base[i][COORD_W-1]}}, base[i]} + {2'b00, quot_q[i]};
			end else begin
				sum[i] = {{2{base[i][COORD_W-1]}}, base[i]} - {2'b00, quot_q[i]};
			end
			if (!sum[i][COORD_W+1] && (sum[i] > POS_MAX)) begin
				pos[i] = POS_MAX[COORD_W-1:0];
			end else if (sum[i][COORD_W+1] && (sum[i] < POS_MIN)) begin
				pos[i] = POS_MIN[COORD_W-1:0];
			end else begin
				pos[i] = sum[i][COORD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			corner_q <= CORNER_START_LEFT;
			valid_q <= 1'b0;
		end else begin
			valid_q <= active_q;
			if (in_valid) begin
				active_q <= 1'b1;
				corner_q <= CORNER_START_LEFT;
			end else if (active_q) begin
				if (corner_q == CORNER_END_RIGHT) begin
					active_q <= 1'b0;
				end
				corner_q <= corner_t'(corner_q + 2'd1);
			end
		end
	end

	// A zero cross product leaves a zero length, so the side offset is forced to zero.
	always_ff @(posedge clk) begin
		if (in_valid) begin
			quot_q <= pts_in.deg ? '0 : quot;
			pts_q <= pts_in;
		end
		pos_q <= pos;
		tu_q <= corner_q[0] ? u_tile : '0;
		tv_q <= corner_q[1] ? TEX_W'(v_offset) : (TEX_W'(v_tile) + TEX_W'(v_offset));
		corner_out_q <= corner_q;
		deg_q <= pts_q.deg;
		last_q <= (corner_q == CORNER_END_RIGHT);
	end

	assign vertex_valid = valid_q;
	assign vertex_x = pos_q[0];
	assign vertex_y = pos_q[1];
	assign vertex_z = pos_q[2];
	assign tex_u = tu_q;
	assign tex_v = tv_q;
	assign corner = corner_out_q;
	assign degenerate = deg_q;
	assign last = last_q;

endmodule

/* tb/tb.sv */
// Testbench for beam_billboard_quad_expand: directed beams from a table, then random beams.
// Each accepted beam is expanded by a local quad predictor; vertex beats are checked in order.
// Depends on rtl/bbq_pkg.sv and rtl/beam_billboard_quad_expand.sv.
`timescale 1ns / 100ps

module tb;
	import bbq_pkg::*;

	typedef struct {
		logic signed [COORD_W-1:0] px, py, pz;
		logic [TEX_W-1:0]          u, v;
		corner_t                   c;
		logic                      deg, lst;
	} vtx_t;

	typedef struct {
		logic signed [COORD_W-1:0] cam [3];
		logic signed [COORD_W-1:0] st [3];
		logic signed [COORD_W-1:0] en [3];
		bit                        flat;
	} beam_t;

	logic clk = 0, arst_n = 0, start = 0, wr_en = 0;
	logic [IDX_W-1:0] wr_index = '0;
	logic [DATA_W-1:0] wr_data = '0;
	logic signed [COORD_W-1:0] camera_x = 0, camera_y = 0, camera_z = 0;
	logic signed [COORD_W-1:0] start_x = 0, start_y = 0, start_z = 0;
	logic signed [COORD_W-1:0] end_x = 0, end_y = 0, end_z = 0;
	logic busy, vertex_valid, degenerate, last;
	logic signed [COORD_W-1:0] vertex_x, vertex_y, vertex_z;
	logic [TEX_W-1:0] tex_u, tex_v;
	logic [1:0] corner;

	logic [HW_W-1:0] cfg_hw = 31'd65536;
	logic [UT_W-1:0] cfg_ut = 16'd256;
	logic [VT_W-1:0] cfg_vt = 15'd256;
	logic [VT_W-1:0] cfg_vo = 15'd0;
	logic [31:0]     cfg_color = 32'hFFFF_FFFF;

	vtx_t pending_vertices [$];
	int   errors = 0;

	beam_billboard_quad_expand dut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	initial begin
		#8_000_000;
		$display("tb: done, errors");
		$finish;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res = 0, b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [COORD_W-1:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	task automatic expand_quad(beam_t b);
		longint a [3], d [3], side [3];
		logic signed [67:0] cr [3];
		logic [67:0] mag [3];
		longint unsigned m [3], sum, len, q;
		int maxlen, s;
		bit flat;
		vtx_t vx;
		longint base;
		maxlen = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = longint'(b.cam[i]) - longint'(b.st[i]);
			d[i] = longint'(b.en[i]) - longint'(b.st[i]);
			side[i] = 0;
		end
		cr[0] = 68'(a[1]) * 68'(d[2]) - 68'(a[2]) * 68'(d[1]);
		cr[1] = 68'(a[2]) * 68'(d[0]) - 68'(a[0]) * 68'(d[2]);
		cr[2] = 68'(a[0]) * 68'(d[1]) - 68'(a[1]) * 68'(d[0]);
		for (int i = 0; i < 3; i++) begin
			mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
			for (int k = 67; k >= 0; k--)
				if (mag[i][k] && k + 1 > maxlen) maxlen = k + 1;
		end
		flat = (maxlen == 0);
		if (!flat) begin
			s = maxlen - NORM_BITS;
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				m[i] = s >= 0 ? 64'(mag[i] >> s) : 64'(mag[i] << (-s));
				sum += m[i] * m[i];
			end
			len = int_sqrt(sum);
			for (int i = 0; i < 3; i++) begin
				q = (m[i] * 64'(cfg_hw)) / len;
				side[i] = cr[i] < 0 ? -longint'(q) : longint'(q);
			end
		end
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 3; i++) begin
				base = k < 2 ? longint'(b.st[i]) : longint'(b.en[i]);
				base = (k & 1) ? base + side[i] : base - side[i];
				if (i == 0) vx.px = clamp32(base);
				else if (i == 1) vx.py = clamp32(base);
				else vx.pz = clamp32(base);
			end
			vx.u = (k & 1) ? cfg_ut : '0;
			vx.v = k < 2 ? TEX_W'(cfg_vt) + TEX_W'(cfg_vo) : TEX_W'(cfg_vo);
			vx.c = corner_t'(k);
			vx.deg = flat;
			vx.lst = (k == 3);
			pending_vertices.push_back(vx);
		end
	endtask

	// Rows marked flat have a zero cross product: the quad collapses onto the end points.
	task automatic expand_flat(beam_t b);
		vtx_t vx;
		for (int k = 0; k < 4; k++) begin
			vx.px = k < 2 ? b.st[0] : b.en[0];
			vx.py = k < 2 ? b.st[1] : b.en[1];
			vx.pz = k < 2 ? b.st[2] : b.en[2];
			vx.u = (k & 1) ? cfg_ut : '0;
			vx.v = k < 2 ? TEX_W'(cfg_vt) + TEX_W'(cfg_vo) : TEX_W'(cfg_vo);
			vx.c = corner_t'(k);
			vx.deg = 1'b1;
			vx.lst = (k == 3);
			pending_vertices.push_back(vx);
		end
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		wr_en = 1;
		wr_index = idx;
		wr_data = val;
		@(posedge clk);
		case (idx)
			REG_HALF_WIDTH: cfg_hw = val[HW_W-1:0];
			REG_U_TILE:     cfg_ut = val[UT_W-1:0];
			REG_V_TILE:     cfg_vt = val[VT_W-1:0];
			REG_V_OFFSET:   cfg_vo = val[VT_W-1:0];
			REG_BEAM_COLOR: cfg_color = val;
			default: ;
		endcase
		@(negedge clk);
		wr_en = 0;
	endtask

	task automatic send_beam(beam_t b, int gap);
		camera_x = b.cam[0]; camera_y = b.cam[1]; camera_z = b.cam[2];
		start_x = b.st[0];   start_y = b.st[1];   start_z = b.st[2];
		end_x = b.en[0];     end_y = b.en[1];     end_z = b.en[2];
		start = 1;
		do @(posedge clk); while (busy);
		if (b.flat) expand_flat(b);
		else expand_quad(b);
		@(negedge clk);
		if (gap > 0) begin
			start = 0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain;
		start = 0;
		while (pending_vertices.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	function automatic logic signed [COORD_W-1:0] rand_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(0, 2097152)) - 1048576;
			2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 70000)
			                               : 32'sh8000_0000 + $urandom_range(0, 70000);
			default: return $signed($urandom_range(0, 512)) - 256;
		endcase
	endfunction

	function automatic beam_t rand_beam();
		beam_t b;
		int mode = $urandom_range(0, 3);
		int kind = $urandom_range(0, 9);
		for (int i = 0; i < 3; i++) begin
			b.cam[i] = rand_coord(mode);
			b.st[i] = rand_coord(mode);
			b.en[i] = rand_coord(mode);
		end
		if (kind == 0) b.cam = b.st;
		else if (kind == 1) b.en = b.st;
		else if (kind == 2) for (int i = 0; i < 3; i++) b.cam[i] = b.st[i] + 2 * (b.en[i] - b.st[i]);
		b.flat = 0;
		return b;
	endfunction

	localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] PMIN = 32'sh8000_0000;
	localparam logic signed [31:0] ONE  = 32'sh0001_0000;

	beam_t directed [] = '{
		'{'{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, 1},
		'{'{PMAX, PMAX, PMAX}, '{PMAX, PMAX, PMAX}, '{PMAX, PMAX, PMAX}, 1},
		'{'{PMIN, PMIN, PMIN}, '{PMIN, PMIN, PMIN}, '{PMIN, PMIN, PMIN}, 1},
		'{'{5, -7, 9}, '{5, -7, 9}, '{ONE, ONE, -ONE}, 1},
		'{'{ONE, 3, 4}, '{-ONE, 2, 0}, '{-ONE, 2, 0}, 1},
		'{'{0, 0, ONE}, '{0, 0, 0}, '{ONE, 0, 0}, 0},
		'{'{0, ONE, 0}, '{0, 0, 0}, '{0, 0, ONE}, 0},
		'{'{ONE, 0, 0}, '{0, 0, 0}, '{0, ONE, 0}, 0},
		'{'{PMIN, 0, PMAX}, '{PMAX, PMAX, 0}, '{PMIN, PMIN, PMIN}, 0},
		'{'{PMAX, PMIN, PMIN}, '{PMIN, PMAX, PMAX}, '{PMAX, PMIN, PMAX}, 0},
		'{'{0, 0, PMIN}, '{PMAX, PMAX, PMAX}, '{PMAX, PMAX - 100, PMAX}, 0},
		'{'{0, 0, PMAX}, '{PMIN, PMIN, PMIN}, '{PMIN, PMIN + 100, PMIN}, 0},
		'{'{PMAX, 0, 0}, '{PMIN, 0, 0}, '{PMIN, PMAX, 0}, 0},
		'{'{-1, 0, 1}, '{0, 0, 0}, '{1, 1, 0}, 0},
		'{'{-1, -1, -1}, '{32'shFFFF_0000, 0, 0}, '{0, 32'shFFFF_0000, 0}, 0}
	};

	always @(posedge clk) begin
		vtx_t e;
		if (arst_n && vertex_valid) begin
			if (pending_vertices.size() == 0) begin
				$error("vertex beat with no beam outstanding");
				errors++;
			end else begin
				e = pending_vertices.pop_front();
				if (vertex_x !== e.px) begin
					$error("vertex_x expected %0d got %0d", e.px, vertex_x); errors++;
				end
				if (vertex_y !== e.py) begin
					$error("vertex_y expected %0d got %0d", e.py, vertex_y); errors++;
				end
				if (vertex_z !== e.pz) begin
					$error("vertex_z expected %0d got %0d", e.pz, vertex_z); errors++;
				end
				if (tex_u !== e.u) begin
					$error("tex_u expected %0h got %0h", e.u, tex_u); errors++;
				end
				if (tex_v !== e.v) begin
					$error("tex_v expected %0h got %0h", e.v, tex_v); errors++;
				end
				if (corner !== e.c) begin
					$error("corner expected %0d got %0d", e.c, corner); errors++;
				end
				if (degenerate !== e.deg) begin
					$error("degenerate expected %0b got %0b", e.deg, degenerate); errors++;
				end
				if (last !== e.lst) begin
					$error("last expected %0b got %0b", e.lst, last); errors++;
				end
			end
		end
	end

	initial begin
		int gap_max;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		foreach (directed[i]) send_beam(directed[i], $urandom_range(0, 3));
		drain();
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					write_reg(REG_HALF_WIDTH, 32'hFFFF_FFFF);
					write_reg(REG_U_TILE, 32'hFFFF_FFFF);
					write_reg(REG_V_TILE, 32'hFFFF_FFFF);
					write_reg(REG_V_OFFSET, 32'hFFFF_FFFF);
					write_reg(REG_BEAM_COLOR, 32'h0);
				end
				1: begin
					write_reg(REG_HALF_WIDTH, 32'h0);
					write_reg(REG_U_TILE, 32'h0);
					write_reg(REG_V_TILE, 32'h0);
					write_reg(REG_V_OFFSET, 32'h0);
				end
				2: begin
					write_reg(3'd5, $urandom);
					write_reg(3'd6, $urandom);
					write_reg(3'd7, $urandom);
				end
				default: begin
					write_reg(REG_HALF_WIDTH, $urandom_range(0, 3) == 0 ? $urandom
						: $urandom_range(1, 1 << 22));
					write_reg(REG_U_TILE, $urandom);
					write_reg(REG_V_TILE, $urandom);
					write_reg(REG_V_OFFSET, $urandom);
					write_reg(REG_BEAM_COLOR, $urandom);
				end
			endcase
			gap_max = (phase % 3 == 1) ? 0 : 18;
			for (int n = 0; n < 26; n++) begin
				if (phase == 4 && n == 13) drain();
				send_beam(rand_beam(), $urandom_range(0, gap_max));
			end
			drain();
		end
		if (errors == 0 && pending_vertices.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

/* filelist.f */
rtl/bbq_pkg.sv
rtl/bbq_front.sv
rtl/bbq_sqrt.sv
rtl/bbq_div.sv
rtl/bbq_emit.sv
rtl/beam_billboard_quad_expand.sv
tb/tb.sv
